FILE: rtl/ifd_pkg.sv
// Shared constants and types for the IMU frame deframer.
package ifd_pkg;

   localparam logic [7:0] SYNC_FIRST    = 8'hAA;
   localparam logic [7:0] SYNC_SECOND   = 8'h55;
   localparam int         FRAME_BYTES   = 14;
   localparam int         PAYLOAD_BYTES = FRAME_BYTES - 1;
   localparam int         INDEX_WIDTH   = $clog2(FRAME_BYTES);
   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(PAYLOAD_BYTES);

   typedef enum logic [1:0] {
      PHASE_HUNT      = 2'd0,
      PHASE_GOT_FIRST = 2'd1,
      PHASE_COLLECT   = 2'd2
   } phase_type;

   // Per-transaction controls from the sync controller to the datapath
   typedef struct packed {
      logic shift_en;    // payload byte goes into the cell chain
      logic frame_good;  // checksum byte matched, capture the frame
      logic last_byte;   // the next byte is the checksum byte
   } ctrl_type;

endpackage

FILE: rtl/ifd_byte_cell.sv
// One byte cell of the payload shift chain.
module ifd_byte_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] data_in,
   output logic [7:0] data_out
);

   logic [7:0] data_ff;
   logic [7:0] byte_in;

   assign byte_in = shift_en ? data_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= byte_in;
   end

   assign data_out = data_ff;

endmodule

FILE: rtl/ifd_sync_ctrl.sv
// Sync hunt, payload count and running checksum.
module ifd_sync_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   output ifd_pkg::ctrl_type ctrl
);

   import ifd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic [7:0]             xor_ff, xor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         index_ff <= '0;
         xor_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         xor_ff   <= xor_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      index_in        = index_ff;
      xor_in          = xor_ff;
      ctrl.shift_en   = 1'b0;
      ctrl.frame_good = 1'b0;
      ctrl.last_byte  = (phase_ff == PHASE_COLLECT) && (index_ff == LAST_INDEX);
      if (accept) begin
         unique case (phase_ff)
            PHASE_GOT_FIRST: begin
               // a wrong second byte is dropped, never retried as a first sync byte
               phase_in = (rx_byte == SYNC_SECOND) ? PHASE_COLLECT : PHASE_HUNT;
               index_in = '0;
               xor_in   = '0;
            end
            PHASE_COLLECT: begin
               if (index_ff != LAST_INDEX) begin
                  ctrl.shift_en = 1'b1;
                  xor_in        = xor_ff ^ rx_byte;
                  index_in      = index_ff + 1'b1;
               end else begin
                  ctrl.frame_good = (rx_byte == xor_ff);
                  phase_in        = PHASE_HUNT;
                  index_in        = '0;
                  xor_in          = '0;
               end
            end
            default: begin
               // hunting, and the unused phase code
               phase_in = (rx_byte == SYNC_FIRST) ? PHASE_GOT_FIRST : PHASE_HUNT;
               index_in = '0;
               xor_in   = '0;
            end
         endcase
      end
   end

   a_shift_xor_good: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.shift_en && ctrl.frame_good))
      else $error("shift and frame capture in the same transaction");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= LAST_INDEX)
      else $error("payload index beyond checksum position");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PHASE_COLLECT) |-> (index_ff == '0 && xor_ff == '0))
      else $error("index or checksum not cleared outside collection");

endmodule

FILE: rtl/imu_frame_deframer_unit.sv
// IMU frame deframer: sync hunt, 13-cell payload chain and result register.
//
// Input channel req_ (valid/ready) carries one serial byte per transaction on
// req_rx_byte. The block hunts for 0xAA then 0x55, then shifts 13 payload
// bytes through a chain of byte cells and compares the 14th byte with the
// XOR of the 13. A matching frame appears on the rsp_ channel (valid/ready)
// as the identifier and six signed words; a bad frame is dropped.
// Throughput: one byte per cycle while req_ready is high. Latency: the result
// is valid in the cycle after the checksum byte is accepted.
// The result register frees the input side: bytes keep flowing while a
// result waits. Only the checksum byte of the following frame is held off
// (req_ready low) while an earlier result is still untaken.
// Reset (synchronous, active high) returns to hunting and clears rsp_valid;
// the payload cells are not reset.
module imu_frame_deframer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_frame_id,
   output logic signed [15:0] rsp_accel_first,
   output logic signed [15:0] rsp_accel_second,
   output logic signed [15:0] rsp_accel_third,
   output logic signed [15:0] rsp_gyro_first,
   output logic signed [15:0] rsp_gyro_second,
   output logic signed [15:0] rsp_gyro_third
);

   import ifd_pkg::*;

   ctrl_type   ctrl;
   logic       accept;
   logic [7:0] cell_data [PAYLOAD_BYTES];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] frame_id_ff;
   logic [15:0] word_ff [6];

   assign req_ready = !rsp_valid_ff || rsp_ready || !ctrl.last_byte;
   assign accept    = req_valid && req_ready;

   ifd_sync_ctrl u_sync_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .ctrl    (ctrl)
   );

   // Cell 0 takes the newest byte; after 13 shifts cell 12 holds payload byte 0
   for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
      if (i == 0) begin : g_head
         ifd_byte_cell u_cell (
            .clock    (clock),
            .shift_en (ctrl.shift_en),
            .data_in  (req_rx_byte),
            .data_out (cell_data[i])
         );
      end else begin : g_body
         ifd_byte_cell u_cell (
            .clock    (clock),
            .shift_en (ctrl.shift_en),
            .data_in  (cell_data[i-1]),
            .data_out (cell_data[i])
         );
      end
   end

   always_comb begin
      priority if (ctrl.frame_good) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Word j: low byte at payload 2j+1, high byte at payload 2j+2
   always_ff @(posedge clock) begin
      if (ctrl.frame_good) begin
         frame_id_ff <= cell_data[PAYLOAD_BYTES-1];
         for (int j = 0; j < 6; j++) begin
            word_ff[j] <= {cell_data[PAYLOAD_BYTES-3-2*j], cell_data[PAYLOAD_BYTES-2-2*j]};
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_id     = frame_id_ff;
   assign rsp_accel_first  = word_ff[0];
   assign rsp_accel_second = word_ff[1];
   assign rsp_accel_third  = word_ff[2];
   assign rsp_gyro_first   = word_ff[3];
   assign rsp_gyro_second  = word_ff[4];
   assign rsp_gyro_third   = word_ff[5];

   a_good_needs_accept: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_good |-> accept)
      else $error("frame captured without an input transaction");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_good |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_good_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_good |=> rsp_valid_ff)
      else $error("good frame not presented");

endmodule
